>>> rtl/plsr_pkg.sv
// ----------------------------------------------------------------------------
// Point light scissor rectangle: shared package
// Fixed-point constants, signed-magnitude type and helpers, configuration
// register indexes and the side record carried through the square root.
// ----------------------------------------------------------------------------
package plsr_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_VIEWPORT = 4096;
  localparam int SIZE_W       = 13;
  localparam int SCALE_W      = FRAC_BITS + 9;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO    = CFG_IDX_W'(2);

  localparam longint SCALE_RAW = longint'(12) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] SCALE_X =
    (FRAC_BITS+1)'(SCALE_RAW / 10 + (((SCALE_RAW % 10) >= 5) ? 1 : 0));

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] c;
    logic        ax_neg;
    logic        ay_neg;
    logic        c_neg;
    logic [30:0] r;
    logic        ok_x;
    logic        ok_y;
  } side_t;

  function automatic smag_t sm_neg(smag_t a);
    smag_t s;
    s.mag = a.mag;
    s.neg = (a.mag != '0) && !a.neg;
    return s;
  endfunction

  function automatic smag_t sm_add(smag_t a, smag_t b);
    smag_t s;
    if (a.neg == b.neg) begin
      s.neg = a.neg;
      s.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      s.neg = a.neg;
      s.mag = a.mag - b.mag;
    end else begin
      s.neg = b.neg;
      s.mag = b.mag - a.mag;
    end
    if (s.mag == '0) begin
      s.neg = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> rtl/plsr_if.sv
// ----------------------------------------------------------------------------
// Point light scissor rectangle: channel interfaces
// Light input channel and rectangle result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plsr_light_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] view_x;
  logic signed [31:0] view_y;
  logic signed [31:0] view_z;
  logic        [30:0] light_radius;

  modport source (output valid, output view_x, output view_y, output view_z,
                  output light_radius, input ready);
  modport sink (input valid, input view_x, input view_y, input view_z,
                input light_radius, output ready);
endinterface

interface plsr_rect_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic        scissor_on;
  logic [12:0] rect_left;
  logic [12:0] rect_top;
  logic [12:0] rect_right;
  logic [12:0] rect_bottom;

  modport source (output valid, output visible, output scissor_on, output rect_left,
                  output rect_top, output rect_right, output rect_bottom, input ready);
  modport sink (input valid, input visible, input scissor_on, input rect_left,
                input rect_top, input rect_right, input rect_bottom, output ready);
endinterface

>>> rtl/plsr_isqrt.sv
// ----------------------------------------------------------------------------
// Point light scissor rectangle: pipelined integer square root
// Two lanes of a 64-bit digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module plsr_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [63:0]      tx,
  input  logic [63:0]      ty,
  input  plsr_pkg::side_t  side_in,
  output logic             out_valid,
  output logic [31:0]      qx,
  output logic [31:0]      qy,
  output plsr_pkg::side_t  side_out
);

  localparam int STAGES = 32;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] res;
  } root_t;

  function automatic root_t root_step(root_t cur, logic [1:0] pair);
    root_t       nxt;
    logic [35:0] cand;
    logic [35:0] trial;
    cand  = {cur.rem[33:0], pair};
    trial = {2'b00, cur.res, 2'b01};
    if (cand >= trial) begin
      nxt.rem = cand - trial;
      nxt.res = {cur.res[30:0], 1'b1};
    end else begin
      nxt.rem = cand;
      nxt.res = {cur.res[30:0], 1'b0};
    end
    return nxt;
  endfunction

  logic            vld  [1:STAGES];
  logic [63:0]     bx   [1:STAGES];
  logic [63:0]     by   [1:STAGES];
  root_t           rtx  [1:STAGES];
  root_t           rty  [1:STAGES];
  plsr_pkg::side_t side [1:STAGES];

  logic            s_vld  [0:STAGES-1];
  logic [63:0]     s_bx   [0:STAGES-1];
  logic [63:0]     s_by   [0:STAGES-1];
  root_t           s_rtx  [0:STAGES-1];
  root_t           s_rty  [0:STAGES-1];
  plsr_pkg::side_t s_side [0:STAGES-1];

  always_comb begin
    s_vld[0]  = in_valid;
    s_bx[0]   = tx;
    s_by[0]   = ty;
    s_rtx[0]  = '0;
    s_rty[0]  = '0;
    s_side[0] = side_in;
    for (int s = 1; s < STAGES; s++) begin
      s_vld[s]  = vld[s];
      s_bx[s]   = bx[s];
      s_by[s]   = by[s];
      s_rtx[s]  = rtx[s];
      s_rty[s]  = rty[s];
      s_side[s] = side[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= STAGES; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      for (int s = 1; s <= STAGES; s++) begin
        vld[s] <= s_vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= STAGES; s++) begin
        bx[s]   <= {s_bx[s-1][61:0], 2'b00};
        by[s]   <= {s_by[s-1][61:0], 2'b00};
        rtx[s]  <= root_step(s_rtx[s-1], s_bx[s-1][63:62]);
        rty[s]  <= root_step(s_rty[s-1], s_by[s-1][63:62]);
        side[s] <= s_side[s-1];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign qx        = rtx[STAGES].res;
  assign qy        = rty[STAGES].res;
  assign side_out  = side[STAGES];

endmodule

>>> rtl/plsr_edge.sv
// ----------------------------------------------------------------------------
// Point light scissor rectangle: edge position unit
// Normalizes a tangent-plane ratio, divides it by a pipelined restoring
// divider and maps the projected coordinate to a pixel edge.
// ----------------------------------------------------------------------------
module plsr_edge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_use,
  input  plsr_pkg::smag_t              nz,
  input  plsr_pkg::smag_t              n,
  input  logic [plsr_pkg::SCALE_W-1:0] scale,
  input  logic [plsr_pkg::SIZE_W-1:0]  size,
  output logic                         out_valid,
  output logic                         out_use,
  output logic [plsr_pkg::SIZE_W-1:0]  pos
);

  localparam int F     = plsr_pkg::FRAC_BITS;
  localparam int PW    = plsr_pkg::SCALE_W + 30;
  localparam int SW    = plsr_pkg::SIZE_W;

  // Stage A: capture.
  logic        a_v, a_use, a_fneg;
  logic [63:0] a_mz, a_mn;
  // Stage B: shift amount.
  logic        b_v, b_use, b_fneg;
  logic [63:0] b_mz, b_mn;
  logic [5:0]  b_k;
  // Stage C: normalized operands.
  logic        c_v, c_use, c_fneg;
  logic [29:0] c_mz, c_mn;
  // Stage D: scaled numerator.
  logic          d_v, d_use, d_fneg, d_mz0;
  logic [PW-1:0] d_prod;
  logic [29:0]   d_mn;
  // Divider stages.
  logic          dv_v    [0:F];
  logic          dv_use  [0:F];
  logic          dv_fneg [0:F];
  logic          dv_sat  [0:F];
  logic [29:0]   dv_mn   [0:F];
  logic [29:0]   dv_rem  [0:F];
  logic [F-1:0]  dv_low  [0:F];
  logic [F-1:0]  dv_q    [0:F];

  logic [6:0]    hb;
  logic          any;
  logic [5:0]    k_next;
  logic [63:0]   v_or;
  logic [63:0]   sh_mz, sh_mn;
  logic [29:0]   st_rem [0:F-1];
  logic [F-1:0]  st_q   [0:F-1];
  logic [F+1:0]  num;
  logic [SW+F+1:0] pprod;
  logic [SW-1:0] pos_next;

  always_comb begin
    v_or = a_mz | a_mn;
    hb   = '0;
    any  = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (v_or[i]) begin
        hb  = 7'(i);
        any = 1'b1;
      end
    end
    k_next = (any && hb >= 7'd30) ? 6'(hb - 7'd29) : 6'd0;
  end

  assign sh_mz = b_mz >> b_k;
  assign sh_mn = b_mn >> b_k;

  always_comb begin
    for (int s = 0; s < F; s++) begin
      logic [30:0] t;
      t = {dv_rem[s], dv_low[s][F-1]};
      if (t >= {1'b0, dv_mn[s]}) begin
        st_rem[s] = 30'(t - {1'b0, dv_mn[s]});
        st_q[s]   = {dv_q[s][F-2:0], 1'b1};
      end else begin
        st_rem[s] = t[29:0];
        st_q[s]   = {dv_q[s][F-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (dv_fneg[F]) begin
      num = {2'b01, {F{1'b0}}} - {2'b00, dv_q[F]};
    end else begin
      num = {2'b01, {F{1'b0}}} + {2'b00, dv_q[F]};
    end
    pprod = size * num;
    if (dv_sat[F]) begin
      pos_next = dv_fneg[F] ? '0 : size;
    end else begin
      pos_next = pprod[SW+F:F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s <= F; s++) begin
        dv_v[s] <= 1'b0;
      end
    end else if (en) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      dv_v[0]   <= d_v;
      for (int s = 1; s <= F; s++) begin
        dv_v[s] <= dv_v[s-1];
      end
      out_valid <= dv_v[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_use  <= in_use;
      a_fneg <= nz.neg != n.neg;
      a_mz   <= nz.mag;
      a_mn   <= n.mag;

      b_use  <= a_use;
      b_fneg <= a_fneg;
      b_mz   <= a_mz;
      b_mn   <= a_mn;
      b_k    <= k_next;

      c_use  <= b_use;
      c_fneg <= b_fneg;
      c_mz   <= sh_mz[29:0];
      c_mn   <= sh_mn[29:0];

      d_use  <= c_use;
      d_fneg <= c_fneg;
      d_mz0  <= c_mz == '0;
      d_prod <= scale * c_mz;
      d_mn   <= c_mn;

      dv_use[0]  <= d_use;
      dv_fneg[0] <= d_fneg;
      dv_sat[0]  <= !d_mz0 && (d_prod >= (PW'(d_mn) << F));
      dv_mn[0]   <= d_mn;
      dv_rem[0]  <= d_prod[F+29:F];
      dv_low[0]  <= d_prod[F-1:0];
      dv_q[0]    <= '0;
      for (int s = 1; s <= F; s++) begin
        dv_use[s]  <= dv_use[s-1];
        dv_fneg[s] <= dv_fneg[s-1];
        dv_sat[s]  <= dv_sat[s-1];
        dv_mn[s]   <= dv_mn[s-1];
        dv_rem[s]  <= st_rem[s-1];
        dv_low[s]  <= {dv_low[s-1][F-2:0], 1'b0};
        dv_q[s]    <= st_q[s-1];
      end

      out_use <= dv_use[F];
      pos     <= pos_next;
    end
  end

endmodule

>>> rtl/point_light_scissor_rect_unit.sv
// ----------------------------------------------------------------------------
// Point light scissor rectangle unit
// Screen scissor rectangle of a point light sphere given in view space.
// ----------------------------------------------------------------------------
// A light transaction on the light channel carries the view-space centre in
// signed Q16.16 and the radius in unsigned Q15.16. For each light one result
// transaction leaves on the scissor channel with the visibility flag, the
// scissor flag and the y-flipped rectangle clamped to the viewport. The user
// must write the viewport size and aspect ratio through cfg_we, cfg_index and
// cfg_data only while no light is in flight; the block does not enforce it.
// The datapath is one pipeline of 61 stages: four for the squares and sums,
// 32 for the square root, two for the tangent-plane products and sums, 22 for
// normalization, the 16-step quotient and the edge mapping, and one output
// register. A light is accepted in every cycle unless the pipeline holds.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and the light channel drops ready; nothing is lost.
// Reset is synchronous: it empties the pipeline and loads the viewport of
// 1280 by 720 pixels and an aspect ratio of 455 in Q8.8.
// ----------------------------------------------------------------------------
module point_light_scissor_rect_unit (
  input  logic                             clk,
  input  logic                             rst,
  plsr_light_if.sink                       light,
  plsr_rect_if.source                      scissor,
  input  logic                             cfg_we,
  input  logic [plsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int F  = plsr_pkg::FRAC_BITS;
  localparam int SW = plsr_pkg::SIZE_W;

  logic                         en;
  logic [12:0]                  reg_w, reg_h;
  logic [15:0]                  reg_aspect;
  logic [SW-1:0]                w, h;
  logic [F+17:0]                scale_prod;
  logic [plsr_pkg::SCALE_W-1:0] scale_x, scale_y;

  // Stage 1 to 4.
  logic            p1_v, p2_v, p3_v, p4_v;
  plsr_pkg::side_t p1_side, p2_side, p3_side, p4_side;
  logic [63:0]     p2_ax2, p2_ay2, p2_c2, p2_rr;
  logic [63:0]     p3_sx, p3_sy, p3_rr;
  logic [63:0]     p4_tx, p4_ty;
  plsr_pkg::side_t p1_side_next;
  plsr_pkg::side_t p4_side_next;

  // Square root output.
  logic            q_v;
  logic [31:0]     qx, qy;
  plsr_pkg::side_t q_side;

  // Products and sums.
  logic            p5_v, p5_en_x, p5_en_y;
  plsr_pkg::smag_t p5_rax, p5_cqx, p5_aqx, p5_ray, p5_cqy, p5_aqy, p5_rc;
  logic            p6_v;
  logic            p6_upx_use, p6_lox_use, p6_upy_use, p6_loy_use;
  plsr_pkg::smag_t p6_upx_n, p6_upx_nz, p6_lox_n, p6_lox_nz;
  plsr_pkg::smag_t p6_upy_n, p6_upy_nz, p6_loy_n, p6_loy_nz;
  plsr_pkg::smag_t upx_n, upx_nz, lox_n, lox_nz, upy_n, upy_nz, loy_n, loy_nz;

  // Edge unit outputs.
  logic            e_v;
  logic            upx_use, lox_use, upy_use, loy_use;
  logic [SW-1:0]   upx_pos, lox_pos, upy_pos, loy_pos;
  logic            unused_v1, unused_v2, unused_v3;

  logic [SW-1:0]   x0, x1, y0, y1;
  logic            vis, sc;

  assign en          = !scissor.valid || scissor.ready;
  assign light.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w      <= 13'd1280;
      reg_h      <= 13'd720;
      reg_aspect <= 16'd455;
    end else if (cfg_we) begin
      case (cfg_index)
        plsr_pkg::REG_VIEWPORT_WIDTH:  reg_w      <= cfg_data[12:0];
        plsr_pkg::REG_VIEWPORT_HEIGHT: reg_h      <= cfg_data[12:0];
        plsr_pkg::REG_ASPECT_RATIO:    reg_aspect <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (reg_w == '0) begin
      w = SW'(1);
    end else if (reg_w > SW'(plsr_pkg::MAX_VIEWPORT)) begin
      w = SW'(plsr_pkg::MAX_VIEWPORT);
    end else begin
      w = reg_w;
    end
    if (reg_h == '0) begin
      h = SW'(1);
    end else if (reg_h > SW'(plsr_pkg::MAX_VIEWPORT)) begin
      h = SW'(plsr_pkg::MAX_VIEWPORT);
    end else begin
      h = reg_h;
    end
  end

  assign scale_prod = (F+18)'(plsr_pkg::SCALE_X) * (F+18)'(reg_aspect) + (F+18)'(128);
  assign scale_x    = plsr_pkg::SCALE_W'(plsr_pkg::SCALE_X);

  always_ff @(posedge clk) begin
    scale_y <= scale_prod[F+16:8];
  end

  always_comb begin
    p1_side_next.ax_neg = light.view_x[31];
    p1_side_next.ax     = light.view_x[31] ? 32'(-light.view_x) : 32'(light.view_x);
    p1_side_next.ay_neg = light.view_y[31];
    p1_side_next.ay     = light.view_y[31] ? 32'(-light.view_y) : 32'(light.view_y);
    p1_side_next.c_neg  = !light.view_z[31] && (light.view_z != '0);
    p1_side_next.c      = light.view_z[31] ? 32'(-light.view_z) : 32'(light.view_z);
    p1_side_next.r      = (light.light_radius == '0) ? 31'd1 : light.light_radius;
    p1_side_next.ok_x   = 1'b0;
    p1_side_next.ok_y   = 1'b0;
  end

  always_comb begin
    p4_side_next      = p3_side;
    p4_side_next.ok_x = p3_sx > p3_rr;
    p4_side_next.ok_y = p3_sy > p3_rr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
      p6_v <= 1'b0;
    end else if (en) begin
      p1_v <= light.valid;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= q_v;
      p6_v <= p5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= p1_side_next;

      p2_side <= p1_side;
      p2_ax2  <= p1_side.ax * p1_side.ax;
      p2_ay2  <= p1_side.ay * p1_side.ay;
      p2_c2   <= p1_side.c * p1_side.c;
      p2_rr   <= p1_side.r * p1_side.r;

      p3_side <= p2_side;
      p3_sx   <= p2_ax2 + p2_c2;
      p3_sy   <= p2_ay2 + p2_c2;
      p3_rr   <= p2_rr;

      p4_side <= p4_side_next;
      p4_tx   <= p3_sx - p3_rr;
      p4_ty   <= p3_sy - p3_rr;
    end
  end

  plsr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p4_v),
    .tx        (p4_tx),
    .ty        (p4_ty),
    .side_in   (p4_side),
    .out_valid (q_v),
    .qx        (qx),
    .qy        (qy),
    .side_out  (q_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p5_en_x    <= q_side.ok_x && (qx != '0);
      p5_en_y    <= q_side.ok_y && (qy != '0);
      p5_rax.mag <= {1'b0, q_side.r} * q_side.ax;
      p5_rax.neg <= q_side.ax_neg;
      p5_ray.mag <= {1'b0, q_side.r} * q_side.ay;
      p5_ray.neg <= q_side.ay_neg;
      p5_rc.mag  <= {1'b0, q_side.r} * q_side.c;
      p5_rc.neg  <= q_side.c_neg;
      p5_cqx.mag <= q_side.c * qx;
      p5_cqx.neg <= q_side.c_neg && (qx != '0);
      p5_cqy.mag <= q_side.c * qy;
      p5_cqy.neg <= q_side.c_neg && (qy != '0);
      p5_aqx.mag <= q_side.ax * qx;
      p5_aqx.neg <= q_side.ax_neg && (qx != '0);
      p5_aqy.mag <= q_side.ay * qy;
      p5_aqy.neg <= q_side.ay_neg && (qy != '0);
    end
  end

  always_comb begin
    upx_n  = plsr_pkg::sm_add(p5_rax, p5_cqx);
    upx_nz = plsr_pkg::sm_add(p5_rc, plsr_pkg::sm_neg(p5_aqx));
    lox_n  = plsr_pkg::sm_add(p5_rax, plsr_pkg::sm_neg(p5_cqx));
    lox_nz = plsr_pkg::sm_add(p5_rc, p5_aqx);
    upy_n  = plsr_pkg::sm_add(p5_ray, p5_cqy);
    upy_nz = plsr_pkg::sm_add(p5_rc, plsr_pkg::sm_neg(p5_aqy));
    loy_n  = plsr_pkg::sm_add(p5_ray, plsr_pkg::sm_neg(p5_cqy));
    loy_nz = plsr_pkg::sm_add(p5_rc, p5_aqy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6_upx_n   <= upx_n;
      p6_upx_nz  <= upx_nz;
      p6_lox_n   <= lox_n;
      p6_lox_nz  <= lox_nz;
      p6_upy_n   <= upy_n;
      p6_upy_nz  <= upy_nz;
      p6_loy_n   <= loy_n;
      p6_loy_nz  <= loy_nz;
      p6_upx_use <= p5_en_x && upx_n.neg;
      p6_lox_use <= p5_en_x && !lox_n.neg && (lox_n.mag != '0);
      p6_upy_use <= p5_en_y && upy_n.neg;
      p6_loy_use <= p5_en_y && !loy_n.neg && (loy_n.mag != '0);
    end
  end

  plsr_edge u_edge_upx (
    .clk (clk), .rst (rst), .en (en), .in_valid (p6_v), .in_use (p6_upx_use),
    .nz (p6_upx_nz), .n (p6_upx_n), .scale (scale_x), .size (w),
    .out_valid (e_v), .out_use (upx_use), .pos (upx_pos)
  );

  plsr_edge u_edge_lox (
    .clk (clk), .rst (rst), .en (en), .in_valid (p6_v), .in_use (p6_lox_use),
    .nz (p6_lox_nz), .n (p6_lox_n), .scale (scale_x), .size (w),
    .out_valid (unused_v1), .out_use (lox_use), .pos (lox_pos)
  );

  plsr_edge u_edge_upy (
    .clk (clk), .rst (rst), .en (en), .in_valid (p6_v), .in_use (p6_upy_use),
    .nz (p6_upy_nz), .n (p6_upy_n), .scale (scale_y), .size (h),
    .out_valid (unused_v2), .out_use (upy_use), .pos (upy_pos)
  );

  plsr_edge u_edge_loy (
    .clk (clk), .rst (rst), .en (en), .in_valid (p6_v), .in_use (p6_loy_use),
    .nz (p6_loy_nz), .n (p6_loy_n), .scale (scale_y), .size (h),
    .out_valid (unused_v3), .out_use (loy_use), .pos (loy_pos)
  );

  always_comb begin
    x0  = lox_use ? lox_pos : '0;
    x1  = (upx_use && (upx_pos < w)) ? upx_pos : w;
    y0  = loy_use ? loy_pos : '0;
    y1  = (upy_use && (upy_pos < h)) ? upy_pos : h;
    vis = (x1 > x0) && (y1 > y0) && (e_v || unused_v1 || unused_v2 || unused_v3 || 1'b1);
    sc  = vis && !((x0 == '0) && (x1 == w) && (y0 == '0) && (y1 == h));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scissor.valid <= 1'b0;
    end else if (en) begin
      scissor.valid <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scissor.visible     <= vis;
      scissor.scissor_on  <= sc;
      scissor.rect_left   <= sc ? x0 : '0;
      scissor.rect_top    <= sc ? SW'(h - y1) : '0;
      scissor.rect_right  <= sc ? x1 : '0;
      scissor.rect_bottom <= sc ? SW'(h - y0) : '0;
    end
  end

endmodule
